// File: hw/rtl/b64se_pkg.sv
// shared types, constants and the character table of the base64 stream encoder
package b64se_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] PAD_CHAR          = 8'h3D;
  localparam logic [7:0] TERM_CHAR_RESET   = 8'h7C;
  localparam logic       TERM_ENABLE_RESET = 1'b1;

  localparam logic [1:0] GROUP_FULL_POS  = 2'd2;
  localparam logic [2:0] LAST_GROUP_IDX  = 3'd3;
  localparam logic [2:0] TERMINATOR_IDX  = 3'd4;

  typedef enum logic [0:0] {
    REG_TERM_ENABLE = 1'b0,
    REG_TERM_CHAR   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_req_t;

  typedef struct packed {
    logic [23:0] triple;
    logic [1:0]  group_pos;
    logic        last;
    logic        term_enable;
    logic [7:0]  term_char;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return 8'(8'h41 + w);
    end else if (v < 6'd52) begin
      return 8'(8'h61 + w - 8'd26);
    end else if (v < 6'd62) begin
      return 8'(8'h30 + w - 8'd52);
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

// File: hw/rtl/b64se_front.sv
// front end: gathers bytes into groups of three and issues one job per group
module b64se_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64se_pkg::in_req_t  in_data,
  input  logic                term_enable,
  input  logic [7:0]          term_char,
  input  logic                q_ready,
  output logic                q_push,
  output b64se_pkg::job_t     q_job
);

  logic [15:0] pending;
  logic [1:0]  group_pos;
  logic [1:0]  pos_eff;
  logic        in_fire;
  logic        group_done;
  logic [23:0] triple;

  assign pos_eff    = (group_pos > b64se_pkg::GROUP_FULL_POS) ? 2'd0 : group_pos;
  assign in_stall   = !q_ready;
  assign in_fire    = in_valid && !in_stall;
  assign group_done = (pos_eff == b64se_pkg::GROUP_FULL_POS) || in_data.last_byte;
  assign q_push     = in_fire && group_done;

  always_comb begin
    case (pos_eff)
      2'd0:    triple = {in_data.data_byte, 16'h0000};
      2'd1:    triple = {pending[7:0], in_data.data_byte, 8'h00};
      default: triple = {pending, in_data.data_byte};
    endcase
  end

  always_comb begin
    q_job.triple      = triple;
    q_job.group_pos   = pos_eff;
    q_job.last        = in_data.last_byte;
    q_job.term_enable = term_enable;
    q_job.term_char   = term_char;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_pos <= 2'd0;
    end else if (in_fire) begin
      group_pos <= group_done ? 2'd0 : 2'(pos_eff + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pending <= {pending[7:0], in_data.data_byte};
    end
  end

endmodule

// File: hw/rtl/b64se_queue.sv
// short job queue between the front and back ends
module b64se_queue #(
  parameter int unsigned DEPTH = b64se_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  b64se_pkg::job_t push_job,
  output logic            ready,
  output logic            head_valid,
  output b64se_pkg::job_t head_job,
  input  logic            pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  b64se_pkg::job_t  entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign ready      = (count != CNT_FULL);
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// File: hw/rtl/b64se_back.sv
// back end: turns jobs into characters via an output register, one per unstalled cycle
module b64se_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  b64se_pkg::job_t     job,
  output logic                job_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output b64se_pkg::out_req_t out_data
);

  logic [2:0]          idx;
  logic [2:0]          final_idx;
  logic [2:0]          data_chars;
  logic                load;
  logic [5:0]          sextet;
  b64se_pkg::out_req_t next_char;

  assign load       = job_valid && (!out_valid || !out_stall);
  assign final_idx  = (job.last && job.term_enable) ? b64se_pkg::TERMINATOR_IDX
                                                    : b64se_pkg::LAST_GROUP_IDX;
  assign job_pop    = load && (idx == final_idx);
  assign data_chars = 3'({1'b0, job.group_pos} + 3'd2);

  always_comb begin
    case (idx[1:0])
      2'd0:    sextet = job.triple[23:18];
      2'd1:    sextet = job.triple[17:12];
      2'd2:    sextet = job.triple[11:6];
      default: sextet = job.triple[5:0];
    endcase
  end

  always_comb begin
    if (idx[2]) begin
      next_char.out_char = job.term_char;
    end else if (idx < data_chars) begin
      next_char.out_char = b64se_pkg::sextet_char(sextet);
    end else begin
      next_char.out_char = b64se_pkg::PAD_CHAR;
    end
    next_char.last_char = job.last && (idx == final_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        idx <= job_pop ? 3'd0 : 3'(idx + 3'd1);
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= next_char;
    end
  end

endmodule

// File: hw/rtl/base64_stream_encoder.sv
// top level of the base64 stream encoder
// Input channel: in_valid/in_stall with in_data (one message byte and a last flag).
// Output channel: out_valid/out_stall with out_data (one character and a last flag).
// Each group of three bytes, or the byte flagged last, becomes a job in a short
// queue; the back end sends four characters per job (data and '=' padding) and,
// on the last job with the terminator enabled, the terminator character as a fifth.
// A group's first character passes through the job queue and the output register
// after its closing byte is accepted. The single-character output register sets the
// throughput: one character per cycle while out_stall is low, four per three bytes.
// Bytes are taken one per cycle while the job queue has room; in_stall rises when
// it is full. A stall on the output holds the shown character and fills the queue.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is the
// terminator enable, index 1 the terminator character. cfg_ready is always high.
// Reset (rst, synchronous) empties the queue, clears the group position, drops
// out_valid and restores terminator enabled with character '|'.
module base64_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64se_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  b64se_pkg::in_req_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output b64se_pkg::out_req_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  logic            term_enable;
  logic [7:0]      term_char;
  logic            q_ready;
  logic            q_push;
  b64se_pkg::job_t q_job;
  logic            head_valid;
  b64se_pkg::job_t head_job;
  logic            q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_enable <= b64se_pkg::TERM_ENABLE_RESET;
      term_char   <= b64se_pkg::TERM_CHAR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (b64se_pkg::reg_idx_t'(cfg_index))
        b64se_pkg::REG_TERM_ENABLE: term_enable <= cfg_data[0];
        b64se_pkg::REG_TERM_CHAR:   term_char   <= cfg_data;
        default: ;
      endcase
    end
  end

  b64se_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .term_enable (term_enable),
    .term_char   (term_char),
    .q_ready     (q_ready),
    .q_push      (q_push),
    .q_job       (q_job)
  );

  b64se_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .ready      (q_ready),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop)
  );

  b64se_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (head_valid),
    .job       (head_job),
    .job_pop   (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/b64se_checker.sv
// port-level checks of the base64 stream encoder and their binding
module b64se_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input b64se_pkg::out_req_t out_data
);

  logic       out_fire;
  logic [1:0] char_pos;
  logic       started;
  logic       prev_pad;

  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_pos <= 2'd0;
      started  <= 1'b0;
      prev_pad <= 1'b0;
    end else if (out_fire) begin
      if (out_data.last_char) begin
        char_pos <= 2'd0;
        started  <= 1'b0;
      end else begin
        char_pos <= 2'(char_pos + 2'd1);
        started  <= 1'b1;
      end
      prev_pad <= (out_data.out_char == b64se_pkg::PAD_CHAR);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output request changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output request shown right after reset");

  a_last_place: assert property (@(posedge clk) disable iff (rst)
    out_fire && out_data.last_char |->
      (char_pos == 2'd3) || (char_pos == 2'd0 && started))
    else $error("last character outside the end of a group");

  a_pad_pair: assert property (@(posedge clk) disable iff (rst)
    out_fire && char_pos == 2'd3 && prev_pad |-> out_data.out_char == b64se_pkg::PAD_CHAR)
    else $error("padding not carried to the end of the group");

endmodule

bind base64_stream_encoder b64se_checker u_b64se_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
